@@ hw/rtl/wheel_odometry_dead_reckoning_unit_defines.svh @@
// assertion macros for the wheel odometry dead reckoning unit
`ifndef WHEEL_ODOMETRY_DEAD_RECKONING_UNIT_DEFINES_SVH
`define WHEEL_ODOMETRY_DEAD_RECKONING_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define WODR_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define WODR_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define WODR_ASSERT_IMPL(label, clk, rst_n, a, b)
`define WODR_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ hw/rtl/wodr_pkg.sv @@
// shared types, codes and constant tables of the odometry unit
package wodr_pkg;
  localparam int CFG_IW  = 3;
  localparam int ATAN_IW = 5;
  localparam int ATAN_N  = 24;
  localparam int CX_W    = 34;
  localparam int ZW      = 40;

  typedef logic [CFG_IW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_IMU_MODE      = 3'd0;
  localparam cfg_idx_t REG_START_X       = 3'd1;
  localparam cfg_idx_t REG_START_Y       = 3'd2;
  localparam cfg_idx_t REG_START_HEADING = 3'd3;
  localparam cfg_idx_t REG_TPT           = 3'd4;
  localparam cfg_idx_t REG_TPI           = 3'd5;

  typedef logic [3:0] op_t;
  localparam op_t OP_TURN = 4'd0;
  localparam op_t OP_FWD  = 4'd1;
  localparam op_t OP_SPD  = 4'd2;
  localparam op_t OP_WRH  = 4'd3;
  localparam op_t OP_WRI  = 4'd4;
  localparam op_t OP_MZ   = 4'd5;
  localparam op_t OP_MCH  = 4'd6;
  localparam op_t OP_MCL  = 4'd7;
  localparam op_t OP_MSH  = 4'd8;
  localparam op_t OP_MSL  = 4'd9;

  typedef struct packed {
    logic               load;
    logic               div_start;
    logic               div_cap;
    logic               mod_cap;
    logic               mul_en;
    logic               z_init;
    logic               cstep_en;
    logic [ATAN_IW-1:0] cstep;
    logic               ph_cap;
    logic               rx_cap;
    logic               commit;
    op_t                op;
  } cmd_t;

  typedef struct packed {
    logic div_idle;
  } stat_t;

  // atan(2^-i) in nano-degrees
  localparam logic [35:0] ATAN_ND [ATAN_N] = '{
    36'd45000000000, 36'd26565051177, 36'd14036243468, 36'd7125016349,
    36'd3576334375,  36'd1789910608,  36'd895173710,   36'd447614171,
    36'd223810500,   36'd111905677,   36'd55952892,    36'd27976453,
    36'd13988227,    36'd6994114,     36'd3497057,     36'd1748528,
    36'd874264,      36'd437132,      36'd218566,      36'd109283,
    36'd54642,       36'd27321,       36'd13660,       36'd6830
  };

  localparam logic [29:0] NANO = 30'd1000000000;
  localparam logic signed [CX_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [ZW-1:0] Z90  = 40'sd90000000000;
  localparam logic signed [ZW-1:0] Z180 = 40'sd180000000000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage

@@ hw/rtl/wheel_odometry_dead_reckoning_unit.sv @@
// top level of the wheel odometry dead reckoning unit
// a request runs through three passes of the shared bit-serial divider, the heading
// wraps, the cordic iterations and the projection multiplies before its result is
// committed; a new request is taken only once the last one is committed
// a finished result waits in the output register while the next request is taken
// reset: synchronous active low; config regs to defaults, position, heading and counts cleared
module wheel_odometry_dead_reckoning_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [111:0]        in_tdata,   // forward_ticks, turn_ticks, imu_heading, elapsed_ms
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [127:0]        out_tdata,  // x_position, y_position, wrapped_heading, speed
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  wodr_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_data
);
  import wodr_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] x_pos, y_pos, spd;
  logic [24:0] wh;

  assign cfg_ready = 1'b1;

  wodr_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wodr_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .forward_ticks   (in_tdata[31:0]),
    .turn_ticks      (in_tdata[63:32]),
    .imu_heading     (in_tdata[88:64]),
    .elapsed_ms      (in_tdata[104:89]),
    .x_position      (x_pos),
    .y_position      (y_pos),
    .wrapped_heading (wh),
    .speed           (spd)
  );

  assign out_tdata = {7'b0, spd, wh, y_pos, x_pos};
endmodule

@@ hw/rtl/wodr_datapath.sv @@
// odometry datapath: shared divider, shared multiplier, cordic and state
module wodr_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wodr_pkg::cmd_t     cmd,
  output wodr_pkg::stat_t    stat,
  input  logic               cfg_wr,
  input  wodr_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [31:0]        forward_ticks,
  input  logic [31:0]        turn_ticks,
  input  logic [24:0]        imu_heading,
  input  logic [15:0]        elapsed_ms,
  output logic [31:0]        x_position,
  output logic [31:0]        y_position,
  output logic [24:0]        wrapped_heading,
  output logic [31:0]        speed
);
  import wodr_pkg::*;

  localparam int DVW = 43 + FRAC_BITS;
  localparam int DSW = (9 + FRAC_BITS > 24) ? 9 + FRAC_BITS : 24;
  localparam int MW  = 33 + FRAC_BITS;
  localparam int WW  = 10 + FRAC_BITS;
  localparam int CW  = $clog2(DVW + 1);
  localparam logic [DSW-1:0] FULL = DSW'(360) << FRAC_BITS;
  localparam logic [DSW-1:0] HALF = DSW'(180) << FRAC_BITS;
  localparam logic [32:0] HALF33 = 33'(180) << FRAC_BITS;
  localparam logic [CW-1:0] DVW_C = CW'(DVW);

  logic               imu_mode_r;
  logic [23:0]        tpt_r, tpi_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic [47:0]        acc_r, last_acc_r;
  logic [31:0]        last_fwd_r, last_trn_r;
  logic [31:0]        fwd_r, trn_r;
  logic [24:0]        imu_r;
  logic [15:0]        ms_r;

  logic [DSW-1:0]     dv_rem_r, dv_den_r;
  logic [DVW-1:0]     dv_quo_r;
  logic [CW-1:0]      dv_cnt_r;
  logic [DVW-1:0]     dv_num;
  logic [DSW-1:0]     dv_den;
  logic [DSW:0]       dv_sh;
  logic               dv_ge;
  logic               dv_round;
  logic [DVW:0]       dv_qr;

  logic [MW-1:0]      m_r;
  logic               dneg_r;
  logic [31:0]        spd_r;
  logic signed [WW-1:0] wh_r, theta_r;
  logic [DSW-1:0]     md_r;
  logic               md_neg_r;

  logic [61:0]        prod_r, ph_r;
  logic [31:0]        mul_a;
  logic [29:0]        mul_b;
  logic [62:0]        rx_r;

  logic signed [ZW-1:0]   z_r;
  logic signed [CX_W-1:0] x_r, y_r;
  logic                   neg_r;

  logic [31:0] out_x_r, out_y_r, out_s_r;
  logic [24:0] out_h_r;

  function automatic logic signed [WW-1:0] wrap_fn(input logic [DSW-1:0] r, input logic neg);
    logic [DSW-1:0]     v;
    logic signed [DSW:0] w;
    v = (neg && r != '0) ? FULL - r : r;
    w = (v > HALF) ? $signed({1'b0, v}) - $signed({1'b0, FULL}) : $signed({1'b0, v});
    return w[WW-1:0];
  endfunction

  // magnitude modulo 360 degrees: 360 = 8*45 and 2^12 is 1 modulo 45,
  // so 12-bit chunks are summed, then a small reciprocal multiply finishes
  function automatic logic [DSW-1:0] mod_full(input logic [47:0] a);
    logic [47:0] hi;
    logic [47:0] h3;
    logic [13:0] s1;
    logic [12:0] s2;
    logic [27:0] qp;
    logic [7:0]  q45;
    logic [12:0] r45;
    logic [8:0]  r360;
    hi   = a >> FRAC_BITS;
    h3   = hi >> 3;
    s1   = 14'(h3[11:0]) + 14'(h3[23:12]) + 14'(h3[35:24]) + 14'(h3[47:36]);
    s2   = 13'(s1[11:0]) + 13'(s1[13:12]);
    qp   = 28'(s2) * 28'(23302);
    q45  = qp[27:20];
    r45  = s2 - 13'(q45) * 13'd45;
    r360 = {r45[5:0], hi[2:0]};
    return DSW'({r360, a[FRAC_BITS-1:0]});
  endfunction

  // encoder deltas at 33 bits
  logic signed [32:0] dturn, dfwd;
  logic [32:0]        dturn_mag, dfwd_mag;
  logic [40:0]        tm, nt;
  logic [47:0]        deg, deg_s;
  logic [23:0]        tpt_eff, tpi_eff;
  logic [15:0]        ms_eff;
  logic [DVW-1:0]     mx, m1000;
  logic signed [48:0] hsum;
  logic signed [47:0] avg;
  logic [47:0]        avg_mag;
  logic signed [33:0] imu_d;
  logic [33:0]        imu_mag;
  logic [47:0]        md_in;
  logic               md_neg_in;

  assign dturn     = $signed({trn_r[31], trn_r}) - $signed({last_trn_r[31], last_trn_r});
  assign dfwd      = $signed({fwd_r[31], fwd_r}) - $signed({last_fwd_r[31], last_fwd_r});
  assign dturn_mag = dturn[32] ? 33'(-dturn) : 33'(dturn);
  assign dfwd_mag  = dfwd[32] ? 33'(-dfwd) : 33'(dfwd);
  assign tm        = {8'b0, dturn_mag};
  assign nt        = (tm << 8) + (tm << 6) + (tm << 5) + (tm << 3);
  assign tpt_eff   = (tpt_r == '0) ? 24'd1 : tpt_r;
  assign tpi_eff   = (tpi_r == '0) ? 24'd1 : tpi_r;
  assign ms_eff    = (ms_r == '0) ? 16'd1 : ms_r;
  assign mx        = DVW'(m_r);
  assign m1000     = (mx << 10) - (mx << 4) - (mx << 3);
  assign hsum      = $signed({acc_r[47], acc_r}) + $signed({last_acc_r[47], last_acc_r});
  assign avg       = hsum[48:1];
  assign avg_mag   = avg[47] ? 48'(-avg) : 48'(avg);
  assign imu_d     = $signed({1'b0, HALF33}) - $signed({9'b0, imu_r});
  assign imu_mag   = imu_d[33] ? 34'(-imu_d) : 34'(imu_d);
  assign md_in     = (cmd.op == OP_WRI) ? 48'(imu_mag) : avg_mag;
  assign md_neg_in = (cmd.op == OP_WRI) ? imu_d[33] : avg[47];

  always_comb begin
    case (cmd.op)
      OP_FWD: begin
        dv_num = DVW'({dfwd_mag, {FRAC_BITS{1'b0}}});
        dv_den = DSW'(tpi_eff);
      end
      OP_SPD: begin
        dv_num = m1000;
        dv_den = DSW'(ms_eff);
      end
      default: begin
        dv_num = DVW'({nt, {FRAC_BITS{1'b0}}});
        dv_den = DSW'(tpt_eff);
      end
    endcase
  end

  // restoring divider, one quotient bit per cycle
  assign dv_sh    = {dv_rem_r, dv_quo_r[DVW-1]};
  assign dv_ge    = dv_sh >= {1'b0, dv_den_r};
  assign dv_round = {dv_rem_r, 1'b0} >= {1'b0, dv_den_r};
  assign dv_qr    = {1'b0, dv_quo_r} + (DVW+1)'(dv_round);
  assign stat.div_idle = (dv_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_cnt_r <= '0;
    end else if (cmd.div_start) begin
      dv_cnt_r <= DVW_C;
    end else if (dv_cnt_r != '0) begin
      dv_cnt_r <= dv_cnt_r - CW'(1);
    end
  end

  logic [DSW:0] dv_diff;
  assign dv_diff = dv_sh - {1'b0, dv_den_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_rem_r <= '0;
      dv_quo_r <= dv_num;
      dv_den_r <= dv_den;
    end else if (dv_cnt_r != '0) begin
      dv_rem_r <= dv_ge ? dv_diff[DSW-1:0] : dv_sh[DSW-1:0];
      dv_quo_r <= {dv_quo_r[DVW-2:0], dv_ge};
    end
  end

  assign deg   = dv_qr[47:0];
  assign deg_s = dturn[32] ? 48'(-deg) : deg;

  logic big;
  assign big = |dv_qr[DVW:31];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fwd_r <= forward_ticks;
      trn_r <= turn_ticks;
      imu_r <= imu_heading;
      ms_r  <= elapsed_ms;
    end
    if (cmd.mod_cap) begin
      md_r     <= mod_full(md_in);
      md_neg_r <= md_neg_in;
    end
    if (cmd.div_cap) begin
      case (cmd.op)
        OP_FWD: begin
          m_r    <= dv_qr[MW-1:0];
          dneg_r <= dfwd[32];
        end
        OP_SPD: begin
          if (dneg_r) spd_r <= big ? 32'h80000000 : 32'(-dv_qr[31:0]);
          else spd_r <= big ? 32'h7fffffff : dv_qr[31:0];
        end
        OP_WRH: wh_r <= wrap_fn(md_r, md_neg_r);
        OP_WRI: theta_r <= imu_mode_r ? wrap_fn(md_r, md_neg_r) : wh_r;
        default: ;
      endcase
    end
  end

  // projection operands
  logic signed [CX_W-1:0] cx, sx;
  logic [CX_W-1:0]        cmag, smag;
  logic signed [39:0]     th40;
  logic [39:0]            th_mag;
  logic [29:0]            mh;

  assign cx     = neg_r ? -x_r : x_r;
  assign sx     = neg_r ? -y_r : y_r;
  assign cmag   = cx[CX_W-1] ? CX_W'(-cx) : CX_W'(cx);
  assign smag   = sx[CX_W-1] ? CX_W'(-sx) : CX_W'(sx);
  assign th40   = {{(40-WW){theta_r[WW-1]}}, theta_r};
  assign th_mag = th40[39] ? 40'(-th40) : 40'(th40);
  assign mh     = 30'(m_r >> 30);

  always_comb begin
    case (cmd.op)
      OP_MCH: begin mul_a = cmag[31:0]; mul_b = mh; end
      OP_MCL: begin mul_a = cmag[31:0]; mul_b = m_r[29:0]; end
      OP_MSH: begin mul_a = smag[31:0]; mul_b = mh; end
      OP_MSL: begin mul_a = smag[31:0]; mul_b = m_r[29:0]; end
      default: begin mul_a = th_mag[31:0]; mul_b = NANO; end
    endcase
  end

  logic [61:0] rnd;
  logic [62:0] proj;
  assign rnd  = (prod_r + (62'd1 << 29)) >> 30;
  assign proj = 63'(ph_r) + 63'(rnd);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= 62'(mul_a) * 62'(mul_b);
    if (cmd.ph_cap) ph_r <= prod_r;
    if (cmd.rx_cap) rx_r <= proj;
  end

  // cordic angle in nano-degrees, folded into [-90,90]
  logic [61:0]            zm;
  logic signed [ZW-1:0]   zpos, z0;
  logic signed [CX_W-1:0] xs, ys;
  logic signed [ZW-1:0]   at;

  assign zm   = (prod_r + (62'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign zpos = $signed(zm[ZW-1:0]);
  assign z0   = theta_r[WW-1] ? -zpos : zpos;
  assign xs   = x_r >>> cmd.cstep;
  assign ys   = y_r >>> cmd.cstep;
  assign at   = $signed({4'b0, ATAN_ND[cmd.cstep]});

  always_ff @(posedge clk) begin
    if (cmd.z_init) begin
      x_r <= GAIN_Q30;
      y_r <= '0;
      if (z0 > Z90) begin
        z_r   <= z0 - Z180;
        neg_r <= 1'b1;
      end else if (z0 < -Z90) begin
        z_r   <= z0 + Z180;
        neg_r <= 1'b1;
      end else begin
        z_r   <= z0;
        neg_r <= 1'b0;
      end
    end else if (cmd.cstep_en) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  // position update
  logic [63:0]        rx64, ry64;
  logic               sgn_x, sgn_y;
  logic signed [63:0] sum_x, sum_y;
  logic signed [31:0] pos_x_nxt, pos_y_nxt;
  logic signed [63:0] whx;

  assign rx64  = 64'(rx_r);
  assign ry64  = 64'(proj);
  assign sgn_x = cx[CX_W-1] != dneg_r;
  assign sgn_y = sx[CX_W-1] != dneg_r;
  assign sum_x = $signed({{32{pos_x_r[31]}}, pos_x_r}) + $signed(sgn_x ? -rx64 : rx64);
  assign sum_y = $signed({{32{pos_y_r[31]}}, pos_y_r}) + $signed(sgn_y ? -ry64 : ry64);
  assign pos_x_nxt = sat32(sum_x);
  assign pos_y_nxt = sat32(sum_y);
  assign whx = {{(64-WW){wh_r[WW-1]}}, wh_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imu_mode_r <= 1'b0;
      tpt_r      <= 24'd143580;
      tpi_r      <= 24'd5243;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      acc_r      <= '0;
      last_acc_r <= '0;
      last_fwd_r <= '0;
      last_trn_r <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_IMU_MODE:      imu_mode_r <= cfg_data[0];
          REG_START_X:       pos_x_r <= cfg_data;
          REG_START_Y:       pos_y_r <= cfg_data;
          REG_START_HEADING: acc_r <= {{23{cfg_data[24]}}, cfg_data[24:0]};
          REG_TPT:           tpt_r <= cfg_data[23:0];
          REG_TPI:           tpi_r <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (cmd.div_cap && cmd.op == OP_TURN) acc_r <= acc_r + deg_s;
      if (cmd.commit) begin
        pos_x_r    <= pos_x_nxt;
        pos_y_r    <= pos_y_nxt;
        last_acc_r <= acc_r;
        last_fwd_r <= fwd_r;
        last_trn_r <= trn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_x_r <= pos_x_nxt;
      out_y_r <= pos_y_nxt;
      out_h_r <= whx[24:0];
      out_s_r <= spd_r;
    end
  end

  assign x_position      = out_x_r;
  assign y_position      = out_y_r;
  assign wrapped_heading = out_h_r;
  assign speed           = out_s_r;
endmodule

@@ hw/rtl/wodr_ctrl.sv @@
// odometry sequencer: steps the divider, cordic and multiplier per sample
`include "wheel_odometry_dead_reckoning_unit_defines.svh"
module wodr_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  wodr_pkg::stat_t  stat,
  output wodr_pkg::cmd_t   cmd
);
  import wodr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DTURN = 4'd1;
  localparam logic [3:0] S_DFWD  = 4'd2;
  localparam logic [3:0] S_DSPD  = 4'd3;
  localparam logic [3:0] S_DWRH  = 4'd4;
  localparam logic [3:0] S_DWRI  = 4'd5;
  localparam logic [3:0] S_MZ    = 4'd6;
  localparam logic [3:0] S_ZI    = 4'd7;
  localparam logic [3:0] S_CORD  = 4'd8;
  localparam logic [3:0] S_MCH   = 4'd9;
  localparam logic [3:0] S_MCL   = 4'd10;
  localparam logic [3:0] S_MSH   = 4'd11;
  localparam logic [3:0] S_MSL   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;
  localparam logic [ATAN_IW-1:0] LAST_STEP = ATAN_IW'(CORDIC_STEPS - 1);

  logic [3:0]         state_r, state_nxt, div_next;
  logic               go_r, go_nxt;
  logic [ATAN_IW-1:0] cstep_r, cstep_nxt;
  logic               out_valid_r, out_valid_nxt;
  op_t                div_op;

  always_comb begin
    case (state_r)
      S_DTURN: begin div_op = OP_TURN; div_next = S_DFWD; end
      S_DFWD:  begin div_op = OP_FWD;  div_next = S_DSPD; end
      S_DSPD:  begin div_op = OP_SPD;  div_next = S_DWRH; end
      S_DWRH:  begin div_op = OP_WRH;  div_next = S_DWRI; end
      default: begin div_op = OP_WRI;  div_next = S_MZ;   end
    endcase
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    go_nxt        = go_r;
    cstep_nxt     = cstep_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DTURN;
        end
      end
      S_DTURN, S_DFWD, S_DSPD: begin
        cmd.op = div_op;
        if (!go_r) begin
          cmd.div_start = 1'b1;
          go_nxt        = 1'b1;
        end else if (stat.div_idle) begin
          cmd.div_cap = 1'b1;
          go_nxt      = 1'b0;
          state_nxt   = div_next;
        end
      end
      // heading wrap: modulo first, then fold to (-180,180]
      S_DWRH, S_DWRI: begin
        cmd.op = div_op;
        if (!go_r) begin
          cmd.mod_cap = 1'b1;
          go_nxt      = 1'b1;
        end else begin
          cmd.div_cap = 1'b1;
          go_nxt      = 1'b0;
          state_nxt   = div_next;
        end
      end
      S_MZ: begin
        cmd.op     = OP_MZ;
        cmd.mul_en = 1'b1;
        state_nxt  = S_ZI;
      end
      S_ZI: begin
        cmd.z_init = 1'b1;
        cstep_nxt  = '0;
        state_nxt  = S_CORD;
      end
      S_CORD: begin
        cmd.cstep_en = 1'b1;
        cmd.cstep    = cstep_r;
        if (cstep_r == LAST_STEP) state_nxt = S_MCH;
        else cstep_nxt = cstep_r + ATAN_IW'(1);
      end
      S_MCH: begin
        cmd.op     = OP_MCH;
        cmd.mul_en = 1'b1;
        state_nxt  = S_MCL;
      end
      S_MCL: begin
        cmd.op     = OP_MCL;
        cmd.mul_en = 1'b1;
        cmd.ph_cap = 1'b1;
        state_nxt  = S_MSH;
      end
      S_MSH: begin
        cmd.op     = OP_MSH;
        cmd.mul_en = 1'b1;
        cmd.rx_cap = 1'b1;
        state_nxt  = S_MSL;
      end
      S_MSL: begin
        cmd.op     = OP_MSL;
        cmd.mul_en = 1'b1;
        cmd.ph_cap = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      cstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      cstep_r     <= cstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `WODR_ASSERT_NEXT(a_load_div, clk, rst_n, in_tvalid && in_tready, state_r == S_DTURN && !go_r)
  `WODR_ASSERT_IMPL(a_cap_idle, clk, rst_n, cmd.div_cap, stat.div_idle && go_r)
  `WODR_ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_tvalid && state_r == S_IDLE)
  `WODR_ASSERT_IMPL(a_step_range, clk, rst_n, state_r == S_CORD, cstep_r <= LAST_STEP)
endmodule

@@ dv/tb_top.sv @@
// self-checking testbench of the wheel odometry dead reckoning unit
module tb_top;
  import wodr_pkg::*;

  localparam int LATENCY = 3 * (16 + 45) + 16 + 11;
  localparam int LIMIT   = 2000000;
  localparam int HOLD    = 2000;
  localparam longint FULL_DEG = 64'sd360 <<< 16;
  localparam longint HALF_DEG = 64'sd180 <<< 16;
  localparam longint NANO_DEG = 64'sd1000000000;
  // indexes past the register list, writes to them must change nothing
  localparam cfg_idx_t REG_SPARE6 = 3'd6;
  localparam cfg_idx_t REG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [31:0] speed;
    logic [24:0] heading;
    logic [31:0] y_pos;
    logic [31:0] x_pos;
  } pose_t;

  typedef struct {
    logic [31:0] fwd;
    logic [31:0] turn;
    logic [24:0] imu;
    logic [15:0] ms;
    bit          typed;
    pose_t       pose;
  } sample_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  cfg_idx_t     cfg_index = REG_IMU_MODE;
  logic [31:0]  cfg_data = '0;

  wheel_odometry_dead_reckoning_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // odometry state mirrored from the block
  bit              imu_sel;
  int unsigned     tpt_reg, tpi_reg;
  longint          last_fwd, last_turn, pos_x, pos_y;
  logic [47:0]     head_acc, head_acc_last;

  pose_t pending_poses[$];
  bit    failed;
  bit    quiet;
  int    n_results;
  int    cycles;
  longint fwd_count, turn_count;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return n / d + (((n % d) * 2 >= d) ? 64'd1 : 64'd0);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap_deg(longint a);
    longint v;
    v = a % FULL_DEG;
    if (v < 0) v += FULL_DEG;
    if (v > HALF_DEG) v -= FULL_DEG;
    return v;
  endfunction

  // rotate the gain-prescaled unit vector to the heading in nano-degrees
  function automatic void rotate(input longint a, output longint c, output longint s);
    longint unsigned zm;
    longint z, x, y, xs, ys;
    bit flip;
    zm = (mag(a) * 64'd1000000000 + 64'd32768) >> 16;
    z = a < 0 ? -longint'(zm) : longint'(zm);
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 1'b0;
    if (z > 90 * NANO_DEG) begin
      z -= 180 * NANO_DEG;
      flip = 1'b1;
    end else if (z < -90 * NANO_DEG) begin
      z += 180 * NANO_DEG;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_ND[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_ND[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint project(longint trig, longint dlen);
    longint unsigned c, m, r;
    c = mag(trig);
    m = mag(dlen);
    r = c * (m >> 30) + ((c * (m & 64'h3fffffff) + (64'd1 << 29)) >> 30);
    return ((trig < 0) != (dlen < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic pose_t advance_pose(sample_t smp);
    longint fwd, trn, dturn, dfwd, sum, avg, wh, theta, c, s, dlen, spd;
    longint unsigned tpt, tpi, ms, n, deg, m, q;
    pose_t p;
    fwd = longint'(signed'(smp.fwd));
    trn = longint'(signed'(smp.turn));
    tpt = tpt_reg == 0 ? 1 : tpt_reg;
    tpi = tpi_reg == 0 ? 1 : tpi_reg;
    ms = smp.ms == 0 ? 1 : smp.ms;

    dturn = trn - last_turn;
    n = mag(dturn) * 360;
    deg = ((n / tpt) << 16) + rdiv((n % tpt) << 16, tpt);
    if (dturn < 0) deg = -deg;
    head_acc = head_acc + deg[47:0];

    sum = longint'(signed'(head_acc)) + longint'(signed'(head_acc_last));
    avg = sum >= 0 ? sum / 2 : -((-sum + 1) / 2);
    wh = wrap_deg(avg);
    theta = imu_sel ? wrap_deg(HALF_DEG - longint'(smp.imu)) : wh;
    rotate(theta, c, s);

    dfwd = fwd - last_fwd;
    m = rdiv(mag(dfwd) << 16, tpi);
    dlen = dfwd < 0 ? -longint'(m) : longint'(m);
    pos_x = sat32(pos_x + project(c, dlen));
    pos_y = sat32(pos_y + project(s, dlen));

    q = m / ms;
    if (q >= (64'd1 << 32)) spd = 64'sd1 <<< 32;
    else spd = longint'(q * 1000 + rdiv((m % ms) * 1000, ms));
    spd = sat32(dlen < 0 ? -spd : spd);

    last_fwd = fwd;
    last_turn = trn;
    head_acc_last = head_acc;
    p.x_pos = pos_x[31:0];
    p.y_pos = pos_y[31:0];
    p.heading = wh[24:0];
    p.speed = spd[31:0];
    return p;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMU_MODE: imu_sel = val[0];
      REG_START_X: pos_x = longint'(signed'(val));
      REG_START_Y: pos_y = longint'(signed'(val));
      REG_START_HEADING: head_acc = {{23{val[24]}}, val[24:0]};
      REG_TPT: tpt_reg = val[23:0];
      REG_TPI: tpi_reg = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(sample_t smp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {7'd0, smp.ms, smp.imu, smp.turn, smp.fwd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (smp.typed) begin
      void'(advance_pose(smp));
      pending_poses.push_back(smp.pose);
    end else begin
      pending_poses.push_back(advance_pose(smp));
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] step_count(longint cnt);
    return cnt[31:0];
  endfunction

  task automatic random_run(int count);
    sample_t smp;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          fwd_count = longint'(signed'($urandom()));
          turn_count = longint'(signed'($urandom()));
        end
        1: begin
          fwd_count += $urandom_range(0, 2000000) - 1000000;
          turn_count += $urandom_range(0, 2000000) - 1000000;
        end
        default: begin
          fwd_count += $urandom_range(0, 40000) - 20000;
          turn_count += $urandom_range(0, 8000) - 4000;
        end
      endcase
      smp.fwd = step_count(fwd_count);
      smp.turn = step_count(turn_count);
      fwd_count = longint'(signed'(smp.fwd));
      turn_count = longint'(signed'(smp.turn));
      smp.imu = ($urandom_range(0, 9) == 0) ? 25'($urandom()) : 25'($urandom_range(0, 23592959));
      case ($urandom_range(0, 5))
        0: smp.ms = 16'($urandom());
        1: smp.ms = 16'd0;
        default: smp.ms = 16'($urandom_range(1, 50));
      endcase
      smp.typed = 1'b0;
      send_sample(smp);
    end
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    pose_t got, want;
    int gap;
    forever begin
      @(negedge clk);
      if (n_results == 50) gap = HOLD;
      else gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata;
      n_results++;
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_poses.pop_front();
        if (got.x_pos !== want.x_pos) begin
          $display("%0t: x_position expected %h actual %h", $time, want.x_pos, got.x_pos);
          failed = 1'b1;
        end
        if (got.y_pos !== want.y_pos) begin
          $display("%0t: y_position expected %h actual %h", $time, want.y_pos, got.y_pos);
          failed = 1'b1;
        end
        if (got.heading !== want.heading) begin
          $display("%0t: wrapped_heading expected %h actual %h", $time, want.heading,
                   got.heading);
          failed = 1'b1;
        end
        if (got.speed !== want.speed) begin
          $display("%0t: speed expected %h actual %h", $time, want.speed, got.speed);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    sample_t plan[$];
    sample_t smp;
    imu_sel = 1'b0;
    tpt_reg = 143580;
    tpi_reg = 5243;
    last_fwd = 0; last_turn = 0; pos_x = 0; pos_y = 0;
    head_acc = '0; head_acc_last = '0;
    fwd_count = 0; turn_count = 0;

    // fwd, turn, imu, ms, typed, expected pose
    plan.push_back('{32'd0, 32'd0, 25'd0, 16'd0, 1'b1, '0});
    plan.push_back('{32'd0, 32'd0, 25'd23592959, 16'd65535, 1'b1, '0});
    plan.push_back('{32'd5243, 32'd35895, 25'd0, 16'd1, 1'b0, '0});
    plan.push_back('{32'h7fffffff, 32'd0, 25'd0, 16'd0, 1'b0, '0});
    plan.push_back('{32'h80000000, 32'h7fffffff, 25'h1ffffff, 16'd1, 1'b0, '0});
    plan.push_back('{32'h7fffffff, 32'h80000000, 25'd0, 16'd65535, 1'b0, '0});
    plan.push_back('{32'h80000000, 32'h80000000, 25'd11796480, 16'd0, 1'b0, '0});
    plan.push_back('{32'h0, 32'd71790, 25'd5898240, 16'd10, 1'b0, '0});
    plan.push_back('{32'hffffeb85, 32'd0, 25'd0, 16'd3, 1'b0, '0});
    plan.push_back('{32'hffffffff, 32'hffffffff, 25'd1, 16'd7, 1'b0, '0});
    plan.push_back('{32'd10486, 32'd143580, 25'd0, 16'd20, 1'b0, '0});
    plan.push_back('{32'd0, 32'd0, 25'd0, 16'hffff, 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) send_sample(plan[i]);
    random_run(40);
    drain();

    // extremes: saturating positions, one-tick scales, IMU heading
    write_reg(REG_IMU_MODE, 32'd1);
    write_reg(REG_START_X, 32'h7fffffff);
    write_reg(REG_START_Y, 32'h80000000);
    write_reg(REG_START_HEADING, 32'd11796480);
    write_reg(REG_TPT, 32'd1);
    write_reg(REG_TPI, 32'd1);
    smp = '{32'd0, 32'd0, 25'h1ffffff, 16'd0, 1'b0, '0};
    send_sample(smp);
    random_run(45);
    drain();

    write_reg(REG_IMU_MODE, 32'd0);
    write_reg(REG_START_X, 32'h80000000);
    write_reg(REG_START_Y, 32'h7fffffff);
    write_reg(REG_START_HEADING, 32'hff4c0000);
    write_reg(REG_TPT, 32'hffffff);
    write_reg(REG_TPI, 32'hffffff);
    quiet = 1'b1;
    random_run(45);
    drain();
    quiet = 1'b0;

    // zero scales act as one, spare indexes do nothing
    write_reg(REG_TPT, 32'd0);
    write_reg(REG_TPI, 32'd0);
    write_reg(REG_SPARE6, $urandom());
    write_reg(REG_SPARE7, $urandom());
    random_run(45);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_IMU_MODE, $urandom_range(0, 1));
      write_reg(REG_START_X, $urandom());
      write_reg(REG_START_Y, $urandom());
      write_reg(REG_START_HEADING, $urandom_range(0, 23592960) - 11796480);
      write_reg(REG_TPT, $urandom_range(1, 300000));
      write_reg(REG_TPI, ph == 3 ? $urandom() : $urandom_range(1, 20000));
      random_run(50);
      drain();
    end

    write_reg(REG_IMU_MODE, 32'd0);
    write_reg(REG_START_X, 32'd0);
    write_reg(REG_START_Y, 32'd0);
    write_reg(REG_START_HEADING, 32'd0);
    write_reg(REG_TPT, 32'd143580);
    write_reg(REG_TPI, 32'd5243);
    random_run(30);
    drain();

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
